[design/sps_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
package sps_pkg;

   localparam int MAX_JOBS = 16;
   localparam int SLOT_W   = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);
   localparam int ID_W     = 8;
   localparam int TIME_W   = 16;
   localparam int PRIO_W   = 4;
   localparam int OP_W     = 2;
   localparam int TDATA_W  = 48;
   localparam int TUSER_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   // best candidate so far, handed cell to cell
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] waiting;
   } cand_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic              load_en;
      logic [SLOT_W-1:0] load_slot;
      logic [ID_W-1:0]   load_id;
      logic [TIME_W-1:0] load_arrival;
      logic [TIME_W-1:0] load_burst;
      logic [PRIO_W-1:0] load_prio;
      logic              commit;
      logic              pick_found;
      logic [SLOT_W-1:0] pick_slot;
      logic [CNT_W-1:0]  loaded_count;
      logic [TIME_W-1:0] cur_time;
   } ctl_type;

endpackage

[design/sps_cell.sv]
// One job slot of the scheduler chain: slot state plus one stage of the min-priority scan.
module sps_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [sps_pkg::SLOT_W-1:0] cell_index,
   input  sps_pkg::ctl_type          ctl,
   input  sps_pkg::cand_type         cand_in,
   output sps_pkg::cand_type         cand_out
);
   import sps_pkg::*;

   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] arrival_ff;
   logic [TIME_W-1:0] remaining_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [TIME_W-1:0] waiting_ff;
   cand_type          cand_ff;
   cand_type          cand_in_next;
   cand_type          self_cand;
   logic              loaded;
   logic              elig;
   logic              better;

   assign loaded = CNT_W'(cell_index) < ctl.loaded_count;
   assign elig   = loaded && (arrival_ff <= ctl.cur_time) && (remaining_ff != '0);

   // strict compare keeps the lower slot on a full tie
   assign better = elig && (!cand_in.found || (prio_ff < cand_in.prio) ||
                   ((prio_ff == cand_in.prio) && (arrival_ff < cand_in.arrival)));

   always_comb begin
      self_cand.found     = 1'b1;
      self_cand.slot      = cell_index;
      self_cand.id        = id_ff;
      self_cand.arrival   = arrival_ff;
      self_cand.remaining = remaining_ff;
      self_cand.prio      = prio_ff;
      self_cand.waiting   = waiting_ff;
      cand_in_next        = better ? self_cand : cand_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_en && (ctl.load_slot == cell_index)) begin
         id_ff        <= ctl.load_id;
         arrival_ff   <= ctl.load_arrival;
         remaining_ff <= ctl.load_burst;
         prio_ff      <= ctl.load_prio;
         waiting_ff   <= '0;
      end else if (ctl.commit && ctl.pick_found) begin
         if (ctl.pick_slot == cell_index) begin
            remaining_ff <= remaining_ff - 1'b1;
         end else if (elig && (waiting_ff != '1)) begin
            waiting_ff <= waiting_ff + 1'b1;
         end
      end
   end

   assign cand_out = cand_ff;

endmodule

[design/preemptive_priority_scheduler_core.sv]
// A tick item scans the chain of MAX_JOBS slot cells, its pick traveling one cell a cycle, and
//   commits the pick into the result register once that register is free. Clear and load items
//   leave the core ready for more items; a tick blocks new items until it commits.
// A new item is taken while an earlier result still waits in the output register.
// Reset (synchronous, active high) empties the table, zeroes the time and drops rsp_tvalid.
// Top level of the preemptive priority scheduler.
module preemptive_priority_scheduler_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // job_id[7:0], arrival[23:8], burst[39:24], priority_req[43:40], zero pad
   input  logic [sps_pkg::TDATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [sps_pkg::OP_W-1:0]    req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // ran_id[7:0], turnaround[23:8], waiting[39:24], all_done[40], zero pad
   output logic [sps_pkg::TDATA_W-1:0] rsp_tdata,
   // idle[0], finished[1]
   output logic [sps_pkg::TUSER_W-1:0] rsp_tuser
);
   import sps_pkg::*;

   // sequencer
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic              req_fire;
   logic              commit;
   op_type            op;

   // global counters
   logic [CNT_W-1:0]  loaded_count_ff, loaded_count_in;
   logic [CNT_W-1:0]  done_count_ff, done_count_in;
   logic [TIME_W-1:0] time_ff, time_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   // request fields
   logic [ID_W-1:0]   f_job_id;
   logic [TIME_W-1:0] f_arrival;
   logic [TIME_W-1:0] f_burst;
   logic [PRIO_W-1:0] f_prio;

   // chain
   ctl_type  ctl;
   cand_type chain [MAX_JOBS+1];
   cand_type pick;
   logic     table_full;
   logic     pick_done;
   logic [TIME_W:0] tat_wide;
   logic [TIME_W-1:0] tat;
   logic [CNT_W-1:0]  done_after;

   assign f_job_id  = req_tdata[7:0];
   assign f_arrival = req_tdata[23:8];
   assign f_burst   = req_tdata[39:24];
   assign f_prio    = req_tdata[43:40];
   assign op        = op_type'(req_tuser);

   assign req_fire   = req_tvalid && req_tready;
   assign table_full = loaded_count_ff >= CNT_W'(MAX_JOBS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (op == OP_TICK)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_cnt_ff == SLOT_W'(MAX_JOBS - 1)) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      commit      = 1'b0;
      scan_cnt_in = '0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SCAN:   scan_cnt_in = scan_cnt_ff + 1'b1;
         ST_COMMIT: commit = !rsp_valid_ff || rsp_tready;
         default:   req_tready = 1'b0;
      endcase
   end

   // chain: cell 0 sees an empty candidate, the last cell holds the pick
   assign chain[0] = '0;
   assign pick     = chain[MAX_JOBS];

   always_comb begin
      ctl.load_en      = req_fire && (op == OP_LOAD) && !table_full;
      ctl.load_slot    = SLOT_W'(loaded_count_ff);
      ctl.load_id      = f_job_id;
      ctl.load_arrival = f_arrival;
      ctl.load_burst   = f_burst;
      ctl.load_prio    = f_prio;
      ctl.commit       = commit;
      ctl.pick_found   = pick.found;
      ctl.pick_slot    = pick.slot;
      ctl.loaded_count = loaded_count_ff;
      ctl.cur_time     = time_ff;
   end

   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
      sps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_W'(g)),
         .ctl        (ctl),
         .cand_in    (chain[g]),
         .cand_out   (chain[g+1])
      );
   end

   // completion math; arrival never exceeds time for a served job
   assign pick_done  = pick.found && (pick.remaining == TIME_W'(1));
   assign tat_wide   = {1'b0, time_ff} - {1'b0, pick.arrival} + 1'b1;
   assign tat        = tat_wide[TIME_W] ? '1 : tat_wide[TIME_W-1:0];
   assign done_after = done_count_ff + CNT_W'(pick_done);

   // counters
   always_comb begin
      loaded_count_in = loaded_count_ff;
      done_count_in   = done_count_ff;
      time_in         = time_ff;
      if (req_fire) begin
         case (op)
            OP_CLEAR: begin
               loaded_count_in = '0;
               done_count_in   = '0;
               time_in         = '0;
            end
            OP_LOAD: begin
               if (!table_full) begin
                  loaded_count_in = loaded_count_ff + 1'b1;
                  if (f_burst == '0) done_count_in = done_count_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end else if (commit) begin
         done_count_in = done_after;
         if (time_ff != '1) time_in = time_ff + 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (commit) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in        = '0;
         rsp_data_in[7:0]   = pick.found ? pick.id : '0;
         rsp_data_in[23:8]  = pick_done ? tat : '0;
         rsp_data_in[39:24] = pick_done ? pick.waiting : '0;
         rsp_data_in[40]    = done_after == loaded_count_ff;
         rsp_user_in[0]     = !pick.found;
         rsp_user_in[1]     = pick_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         scan_cnt_ff     <= '0;
         loaded_count_ff <= '0;
         done_count_ff   <= '0;
         time_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         scan_cnt_ff     <= scan_cnt_in;
         loaded_count_ff <= loaded_count_in;
         done_count_ff   <= done_count_in;
         time_ff         <= time_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[design/sps_checker.sv]
// Port-level checks for the scheduler core, bound to the top level.
module sps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [sps_pkg::TDATA_W-1:0] req_tdata,
   input logic [sps_pkg::OP_W-1:0]    req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [sps_pkg::TDATA_W-1:0] rsp_tdata,
   input logic [sps_pkg::TUSER_W-1:0] rsp_tuser
);
   import sps_pkg::*;

   // no result is left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an idle tick names no job and completes nothing
   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[7:0] == '0) && !rsp_tuser[1])
      else $error("idle result carries a job");

   // a completion has at least one tick of turnaround and is not idle
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata[23:8] != '0) && !rsp_tuser[0])
      else $error("bad completion result");

   // a tick occupies the scan chain, so the next item waits
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_TICK) |=> !req_tready)
      else $error("item taken during scan");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind preemptive_priority_scheduler_core sps_checker u_sps_checker (.*);
